// ===== rtl/itoa_pkg.sv =====
// shared types, codes and helpers of the integer to ascii formatter
package itoa_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_EMIT
    } itoa_state_t;

    localparam logic [1:0] ACT_UDEC = 2'd0;
    localparam logic [1:0] ACT_SDEC = 2'd1;
    localparam logic [1:0] ACT_HEX  = 2'd2;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_ALPHA = 7'h57;
    localparam logic [6:0] CH_MINUS = 7'h2d;
    localparam logic [6:0] CH_SPACE = 7'h20;

    typedef struct packed {
        logic load;
        logic load_hex;
        logic dabble;
        logic shift;
    } itoa_cmd_t;

    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {3'b000, d};
        end else begin
            c = CH_ALPHA + {3'b000, d};
        end
        return c;
    endfunction

endpackage

// ===== rtl/itoa_digit_unit.sv =====
// shift-and-add-3 digit register shared by decimal and hex conversion
module itoa_digit_unit #(
    parameter int VALUE_BITS = 32,
    parameter int NUM_DIGITS = 10
) (
    input  logic                      aclk,
    input  itoa_pkg::itoa_cmd_t       cmd,
    input  logic [VALUE_BITS-1:0]     load_mag,
    output logic [3:0]                top_digit
);
    import itoa_pkg::*;

    localparam int DB = 4 * NUM_DIGITS;

    logic [VALUE_BITS-1:0] mag_reg;
    logic [VALUE_BITS-1:0] mag_next;
    logic [DB-1:0]         bcd_reg;
    logic [DB-1:0]         bcd_next;
    logic [DB-1:0]         bcd_adj;

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        if (cmd.load) begin
            mag_next = load_mag;
            if (cmd.load_hex) begin
                bcd_next = {{(DB-VALUE_BITS){1'b0}}, load_mag};
            end else begin
                bcd_next = '0;
            end
        end else if (cmd.dabble) begin
            bcd_next = {bcd_adj[DB-2:0], mag_reg[VALUE_BITS-1]};
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
        end else if (cmd.shift) begin
            bcd_next = {bcd_reg[DB-5:0], 4'h0};
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign top_digit = bcd_reg[DB-1 -: 4];

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// integer to ascii formatter top level: sequencer, padding and output register
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  value, min_width, zero_pad; action in tuser
// m_axis    out  m_axis_tvalid / m_axis_tready  out_char; last as tlast
//
// one item takes a load step, then a shift-and-add-3 step for each value bit in decimal (none in hex),
// then a shift for each suppressed leading zero and a closing normalize step, then an emit step per character
// input ready only in idle; output register lets the last character wait meanwhile
// a stalled output holds the sequencer in its emit step
// aresetn clears the sequencer and the output valid
module integer_to_ascii_formatter #(
    parameter int MAX_FIELD_WIDTH = 31,
    parameter int VALUE_BITS      = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], min_width[36:32], zero_pad[37]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_char[6:0]
    output logic        m_axis_tlast
);
    import itoa_pkg::*;

    localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int DW = $clog2(NUM_DIGITS + 1);
    localparam int BW = $clog2(VALUE_BITS + 1);
    localparam int FW = $clog2(MAX_FIELD_WIDTH + 1);
    localparam int CW = (FW > DW + 1) ? FW : DW + 1;

    itoa_state_t state_reg, state_next;
    logic [BW-1:0] bitcnt_reg, bitcnt_next;
    logic [DW-1:0] ndig_reg, ndig_next;
    logic [FW-1:0] pad_reg, pad_next;
    logic          sign_reg, sign_next;
    logic          zpad_reg, zpad_next;
    logic [FW-1:0] wid_reg, wid_next;
    logic          m_valid_reg, m_valid_next;
    logic [6:0]    m_char_reg, m_char_next;
    logic          m_last_reg, m_last_next;

    itoa_cmd_t             cmd;
    logic [3:0]            top_digit;
    logic [VALUE_BITS-1:0] in_v;
    logic [VALUE_BITS-1:0] in_mag;
    logic                  in_neg;
    logic [4:0]            in_width;
    logic [CW-1:0]         text_len;
    logic [CW-1:0]         wid_ext;

    generate
        if (VALUE_BITS <= 32) begin : g_narrow
            assign in_v = s_axis_tdata[VALUE_BITS-1:0];
        end else begin : g_wide
            assign in_v = {{(VALUE_BITS-32){1'b0}}, s_axis_tdata[31:0]};
        end
    endgenerate

    assign in_width = s_axis_tdata[36:32];
    assign in_neg   = (s_axis_tuser == ACT_SDEC) && in_v[VALUE_BITS-1];
    assign in_mag   = in_neg ? (~in_v + VALUE_BITS'(1)) : in_v;
    assign text_len = CW'(ndig_reg) + CW'(sign_reg);
    assign wid_ext  = CW'(wid_reg);

    itoa_digit_unit #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_digits (
        .aclk      (aclk),
        .cmd       (cmd),
        .load_mag  (in_mag),
        .top_digit (top_digit)
    );

    always_comb begin
        state_next    = state_reg;
        bitcnt_next   = bitcnt_reg;
        ndig_next     = ndig_reg;
        pad_next      = pad_reg;
        sign_next     = sign_reg;
        zpad_next     = zpad_reg;
        wid_next      = wid_reg;
        m_valid_next  = m_valid_reg;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.load     = 1'b1;
                    cmd.load_hex = (s_axis_tuser == ACT_HEX);
                    sign_next    = in_neg;
                    zpad_next    = s_axis_tdata[37];
                    if (32'(in_width) > 32'(MAX_FIELD_WIDTH)) begin
                        wid_next = FW'(MAX_FIELD_WIDTH);
                    end else begin
                        wid_next = FW'(in_width);
                    end
                    ndig_next   = DW'(NUM_DIGITS);
                    bitcnt_next = BW'(VALUE_BITS);
                    if (s_axis_tuser == ACT_HEX) begin
                        state_next = ST_NORM;
                    end else begin
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                cmd.dabble  = 1'b1;
                bitcnt_next = bitcnt_reg - BW'(1);
                if (bitcnt_reg == BW'(1)) begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                if ((top_digit == 4'h0) && (ndig_reg > DW'(1))) begin
                    cmd.shift = 1'b1;
                    ndig_next = ndig_reg - DW'(1);
                end else begin
                    if (wid_ext > text_len) begin
                        pad_next = FW'(wid_ext - text_len);
                    end else begin
                        pad_next = '0;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    if (pad_reg != '0) begin
                        m_char_next = zpad_reg ? CH_ZERO : CH_SPACE;
                        m_last_next = 1'b0;
                        pad_next    = pad_reg - FW'(1);
                    end else if (sign_reg) begin
                        m_char_next = CH_MINUS;
                        m_last_next = 1'b0;
                        sign_next   = 1'b0;
                    end else begin
                        m_char_next = digit_char(top_digit);
                        m_last_next = (ndig_reg == DW'(1));
                        cmd.shift   = 1'b1;
                        ndig_next   = ndig_reg - DW'(1);
                        if (ndig_reg == DW'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            bitcnt_reg  <= '0;
            ndig_reg    <= '0;
            pad_reg     <= '0;
            sign_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            bitcnt_reg  <= bitcnt_next;
            ndig_reg    <= ndig_next;
            pad_reg     <= pad_next;
            sign_reg    <= sign_next;
        end
    end

    always_ff @(posedge aclk) begin
        zpad_reg   <= zpad_next;
        wid_reg    <= wid_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_char_reg};
    assign m_axis_tlast  = m_last_reg;

    a_start_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted transfer did not start the sequencer");

    a_conv_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV) |-> (bitcnt_reg != '0))
        else $error("conversion step with exhausted bit count");

    a_digits_left: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_NORM) || (state_reg == ST_EMIT)) |-> (ndig_reg != '0))
        else $error("no digit left to print");

    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (((m_char_reg >= CH_ZERO) && (m_char_reg <= 7'h39))
                      || ((m_char_reg >= 7'h61) && (m_char_reg <= 7'h66))
                      || (m_char_reg == CH_MINUS) || (m_char_reg == CH_SPACE)))
        else $error("character outside pad, sign and digit set");

endmodule

// ===== tb/integer_to_ascii_formatter_tb.sv =====
// testbench of the integer to ascii formatter: directed and random values checked per character
module integer_to_ascii_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itoa_pkg::*;

    localparam int MAX_FIELD_WIDTH = 31;
    localparam int VALUE_BITS      = 32;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } text_char_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // value[31:0], min_width[36:32], zero_pad[37]
    logic [1:0]  s_axis_tuser;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // out_char[6:0]
    logic        m_axis_tlast;

    text_char_t pending_chars[$];
    int         mismatch_count = 0;
    bit         calm = 0;
    int         hold_request = 0;

    integer_to_ascii_formatter #(
        .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH),
        .VALUE_BITS     (VALUE_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // expected text of one value, pads first, then sign, then digits
    function automatic void predict_text(input logic [31:0] value, input logic [1:0] action,
                                         input logic [4:0] min_width, input logic zero_pad);
        logic [31:0] mag;
        logic [31:0] base;
        logic [3:0]  d;
        logic [6:0]  text[$];
        logic [6:0]  digits[$];
        int          field;
        int          pad_n;
        int          total;
        text_char_t  c;
        mag  = value;
        base = 32'd10;
        if (action == ACT_HEX) begin
            base = 32'd16;
        end else if (action == ACT_SDEC && value[31]) begin
            mag = -value;
            text.push_back(CH_MINUS);
        end
        do begin
            d = 4'(mag % base);
            mag = mag / base;
            if (d < 4'd10) begin
                digits.push_front(7'h30 + 7'(d));
            end else begin
                digits.push_front(7'h61 + 7'(d) - 7'd10);
            end
        end while (mag != 0);
        foreach (digits[i]) text.push_back(digits[i]);
        field = (min_width > MAX_FIELD_WIDTH) ? MAX_FIELD_WIDTH : int'(min_width);
        pad_n = (field > text.size()) ? field - text.size() : 0;
        total = pad_n + text.size();
        for (int k = 0; k < total; k++) begin
            c.ch   = (k < pad_n) ? (zero_pad ? CH_ZERO : CH_SPACE) : text[k - pad_n];
            c.last = (k == total - 1);
            pending_chars.push_back(c);
        end
    endfunction

    task automatic note_mismatch(input string what, input text_char_t want, input text_char_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch (%s): expected char %h last %b, got char %h last %b",
                     what, want.ch, want.last, got.ch, got.last);
        end
    endtask

    always @(posedge aclk) begin
        text_char_t got;
        text_char_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.ch   = m_axis_tdata[6:0];
            got.last = m_axis_tlast;
            if (pending_chars.size() == 0) begin
                note_mismatch("unexpected transfer", '0, got);
            end else begin
                want = pending_chars.pop_front();
                if (got.ch !== want.ch) note_mismatch("out_char", want, got);
                if (got.last !== want.last) note_mismatch("last", want, got);
            end
        end
    end

    // receiver: random short stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 3) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_value(input logic [31:0] value, input logic [1:0] action,
                              input logic [4:0] min_width, input logic zero_pad);
        int gap;
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, zero_pad, min_width, value};
        s_axis_tuser  <= action;
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        predict_text(value, action, min_width, zero_pad);
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    task automatic test_extremes();
        send_value(32'h0000_0000, ACT_UDEC, 5'd0,  1'b0);
        send_value(32'hFFFF_FFFF, ACT_UDEC, 5'd0,  1'b0);
        send_value(32'h0000_0000, ACT_SDEC, 5'd0,  1'b1);
        send_value(32'hFFFF_FFFF, ACT_SDEC, 5'd0,  1'b0);
        send_value(32'h8000_0000, ACT_SDEC, 5'd0,  1'b0);
        send_value(32'h7FFF_FFFF, ACT_SDEC, 5'd0,  1'b0);
        send_value(32'h0000_0000, ACT_HEX,  5'd0,  1'b0);
        send_value(32'hFFFF_FFFF, ACT_HEX,  5'd31, 1'b1);
        send_value(32'hDEAD_BEEF, ACT_HEX,  5'd0,  1'b0);
        send_value(32'h8000_0000, ACT_UDEC, 5'd31, 1'b0);
    endtask

    task automatic test_unused_action();
        send_value(32'h8000_0000, 2'd3, 5'd0,  1'b0);
        send_value(32'd1234567,   2'd3, 5'd12, 1'b1);
    endtask

    task automatic test_padding();
        send_value(32'h8000_0000, ACT_SDEC, 5'd31, 1'b1);
        send_value(32'hFFFF_FFF6, ACT_SDEC, 5'd31, 1'b0);
        send_value(32'd4294967,   ACT_UDEC, 5'd3,  1'b1);
        send_value(32'd42,        ACT_UDEC, 5'd2,  1'b0);
        send_value(32'hFFFF_FFFF, ACT_SDEC, 5'd2,  1'b1);
        send_value(32'h0000_00AB, ACT_HEX,  5'd1,  1'b0);
        send_value(32'd7,         ACT_UDEC, 5'd1,  1'b1);
        send_value(32'd0,         ACT_UDEC, 5'd31, 1'b0);
    endtask

    task automatic test_backpressure();
        hold_request = 150;
        send_value(32'hFFFF_FFFF, ACT_UDEC, 5'd31, 1'b0);
        send_value(32'h8000_0000, ACT_SDEC, 5'd20, 1'b1);
        send_value(32'h1234_ABCD, ACT_HEX,  5'd0,  1'b0);
        send_value(32'd99,        ACT_UDEC, 5'd4,  1'b1);
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        send_value(32'd10,        ACT_UDEC, 5'd0,  1'b0);
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 20);
            2: v = 32'hFFFF_FFFF - $urandom_range(0, 20);
            3: v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_value(random_value(), 2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                       1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_extremes();
        test_unused_action();
        test_padding();
        test_backpressure();
        test_random(225);
        calm = 1;
        test_random(25);

        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
